FILE: rtl/core/bffpa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap first-fit page allocator - shared definitions
// Operation codes, controller states, map word geometry and the structs
// passed between the controller and the word unit.
// ----------------------------------------------------------------------------
package bffpa_pkg;

	localparam int PAGES_DEF = 512;          // default map size in pages
	localparam int WORD_W    = 8;            // map bits per memory word
	localparam int WSH       = 3;            // log2(WORD_W)
	localparam int PG_W      = 11;           // page numbers and limits (up to 1534)
	localparam int CNT_W     = 10;           // page_count / run length / free count
	localparam int START_W   = 9;
	localparam int FADD_W    = 4;            // free bits in one word, 0..8
	localparam logic [9:0] ACTIVE_RESET = 10'd512;

	typedef enum logic [1:0] {
		OP_CHECK   = 2'd0,
		OP_SEARCH  = 2'd1,
		OP_RESERVE = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	// context for one map word
	typedef struct packed {
		op_t               op;
		logic [CNT_W-1:0]  count;
		logic [PG_W-1:0]   lo;     // first page of mark range
		logic [PG_W-1:0]   hi;     // end of mark range, clipped to limit
		logic [PG_W-1:0]   lim;    // effective active pages
		logic [PG_W-1:0]   base;   // page number of bit 0
		logic [CNT_W-1:0]  run;    // free run carried in from earlier words
	} word_cmd_t;

	typedef struct packed {
		logic              wr;
		logic [WORD_W-1:0] wdata;
		logic [FADD_W-1:0] free_add;
		logic [CNT_W-1:0]  run;
		logic              hit;
		logic [PG_W-1:0]   first;
	} word_res_t;

endpackage

FILE: rtl/core/bffpa_map_ram.sv
// ----------------------------------------------------------------------------
// Occupancy map memory
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module bffpa_map_ram import bffpa_pkg::*; #(
	parameter int DEPTH  = PAGES_DEF / WORD_W,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/bffpa_word_unit.sv
// ----------------------------------------------------------------------------
// Map word unit
// Works on one map word: free count, first-fit run tracking and range marking.
// ----------------------------------------------------------------------------
module bffpa_word_unit import bffpa_pkg::*; (
	input  word_cmd_t         cmd,
	input  logic [WORD_W-1:0] data,
	output word_res_t         res
);

	always_comb begin
		logic [PG_W-1:0]   page;
		logic [CNT_W-1:0]  run;
		logic [FADD_W-1:0] fcnt;
		logic              hit;
		logic [PG_W-1:0]   first;
		logic [WORD_W-1:0] wd;
		logic              set_val;
		run     = cmd.run;
		fcnt    = '0;
		hit     = 1'b0;
		first   = '0;
		wd      = data;
		set_val = (cmd.op == OP_RESERVE);
		for (int b = 0; b < WORD_W; b++) begin
			page = cmd.base + PG_W'(b);
			if (page < cmd.lim) begin
				if (!data[b]) begin
					fcnt = fcnt + FADD_W'(1);
				end
				if (!hit) begin
					if (data[b]) begin
						run = '0;
					end else begin
						run = run + CNT_W'(1);
						if (run >= cmd.count) begin
							hit   = 1'b1;
							first = page + PG_W'(1) - {1'b0, run};
						end
					end
				end
			end
			if (page >= cmd.lo && page < cmd.hi) begin
				wd[b] = set_val;
			end
		end
		res.wr       = (cmd.op == OP_RESERVE) || (cmd.op == OP_RELEASE);
		res.wdata    = wd;
		res.free_add = fcnt;
		res.run      = run;
		res.hit      = hit;
		res.first    = first;
	end

endmodule

FILE: rtl/core/bitmap_first_fit_page_allocator_top.sv
// ----------------------------------------------------------------------------
// Bitmap first-fit page allocator
// One occupancy bit per page kept in a word-wide RAM; space check, first-fit
// search, reserve and release walk the map one word per cycle.
// ----------------------------------------------------------------------------
// Usage:
//  - cfg channel writes active_pages (values above NUM_PAGES act as NUM_PAGES);
//    write it only while no request is in flight.
//  - s_* carries one request per transfer, m_* one result per request.
//  - A request reads N = ceil(active/8) map words, one per cycle. Its result is
//    loaded once the walk ends and the output register is free, and the next
//    request is taken after that. A search stops at the word holding the run.
//  - One request is worked on at a time; the next one is taken as soon as
//    the result sits in the output register, even if m_tready is low.
//  - After reset the map RAM is cleared, one word per cycle; s_tready stays low
//    until that is done.
//  - A stalled result holds m_tdata; the finished request waits in the core
//    until the output register frees.
// ----------------------------------------------------------------------------
module bitmap_first_fit_page_allocator_top import bffpa_pkg::*; #(
	parameter int NUM_PAGES = PAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [9:0]  cfg_data,     // active_pages
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,      // page_count[9:0], start_page[18:10], zero pad
	input  logic [1:0]  s_tuser,      // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata       // found[0], first_page[9:1], free_pages[19:10], pad
);

	localparam int DEPTH  = (NUM_PAGES + WORD_W - 1) / WORD_W;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WC_W   = $clog2(DEPTH + 1);

	state_t state_q, state_d;

	logic [9:0]         active_q;
	op_t                op_q;
	logic [CNT_W-1:0]   count_q;
	logic [PG_W-1:0]    lo_q, hi_q, lim_q;
	logic [WC_W-1:0]    nwords_q, rd_cnt_q;
	logic [ADDR_W-1:0]  clr_cnt_q, addr_s1;
	logic               valid_s1, last_s1;
	logic [CNT_W-1:0]   run_q, free_q;
	logic               hit_q;
	logic [PG_W-1:0]    first_q;
	logic               m_tvalid_q;
	logic [23:0]        m_tdata_q;

	logic [PG_W-1:0]    lim_c, sum_c, hi_c, base_c, addr_ext;
	logic [WC_W-1:0]    nwords_c;
	logic               accept, issue, finish, load_out, out_found;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [WORD_W-1:0]  mem_wdata, mem_rdata;
	word_cmd_t          cmd;
	word_res_t          res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg_valid) begin
			active_q <= cfg_data;
		end
	end

	// request decode at accept
	always_comb begin
		lim_c    = (32'(active_q) > NUM_PAGES) ? PG_W'(NUM_PAGES) : PG_W'(active_q);
		sum_c    = {2'b00, s_tdata[18:10]} + {1'b0, s_tdata[9:0]};
		hi_c     = (sum_c > lim_c) ? lim_c : sum_c;
		nwords_c = WC_W'((lim_c + PG_W'(WORD_W - 1)) >> WSH);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		accept   = 1'b0;
		issue    = 1'b0;
		finish   = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					accept  = 1'b1;
					state_d = (nwords_c == '0) ? ST_HOLD : ST_RUN;
				end
			end
			ST_RUN: begin
				finish = valid_s1 && (last_s1 || (op_q == OP_SEARCH && res.hit));
				issue  = !finish && (rd_cnt_q < nwords_q);
				if (finish) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				load_out = !m_tvalid_q || m_tready;
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			end
			valid_s1 <= issue;
		end
	end

	// request context, read walk and accumulators
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op_t'(s_tuser);
			count_q  <= s_tdata[9:0];
			lo_q     <= {2'b00, s_tdata[18:10]};
			hi_q     <= hi_c;
			lim_q    <= lim_c;
			nwords_q <= nwords_c;
			rd_cnt_q <= '0;
			run_q    <= '0;
			free_q   <= '0;
			hit_q    <= 1'b0;
			first_q  <= '0;
		end else begin
			if (issue) begin
				rd_cnt_q <= rd_cnt_q + WC_W'(1);
			end
			if (state_q == ST_RUN && valid_s1) begin
				run_q  <= res.run;
				free_q <= free_q + CNT_W'(res.free_add);
				if (res.hit) begin
					hit_q   <= 1'b1;
					first_q <= res.first;
				end
			end
		end
		addr_s1 <= rd_cnt_q[ADDR_W-1:0];
		last_s1 <= (rd_cnt_q == nwords_q - WC_W'(1));
	end

	assign addr_ext = PG_W'(addr_s1);
	assign base_c   = {addr_ext[PG_W-WSH-1:0], {WSH{1'b0}}};

	always_comb begin
		cmd.op    = op_q;
		cmd.count = count_q;
		cmd.lo    = lo_q;
		cmd.hi    = hi_q;
		cmd.lim   = lim_q;
		cmd.base  = base_c;
		cmd.run   = run_q;
	end

	bffpa_word_unit u_word (
		.cmd  (cmd),
		.data (mem_rdata),
		.res  (res)
	);

	// write port: clearing pass after reset, else read-modify-write of the walk
	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
			mem_wdata = '0;
		end else begin
			mem_we    = (state_q == ST_RUN) && valid_s1 && res.wr;
			mem_waddr = addr_s1;
			mem_wdata = res.wdata;
		end
	end

	bffpa_map_ram #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (rd_cnt_q[ADDR_W-1:0]),
		.rdata (mem_rdata)
	);

	// output register
	always_comb begin
		unique case (op_q)
			OP_CHECK:  out_found = (free_q >= count_q);
			OP_SEARCH: out_found = hit_q;
			default:   out_found = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {4'b0000,
				(op_q == OP_CHECK) ? free_q : {CNT_W{1'b0}},
				(op_q == OP_SEARCH && hit_q) ? first_q[START_W-1:0] : {START_W{1'b0}},
				out_found};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// checks
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !s_tready)
		else $error("request taken during map clear");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while one is in flight");

	a_no_write_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE || state_q == ST_HOLD |-> !mem_we)
		else $error("map write outside a walk or clear");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !m_tvalid || m_tready)
		else $error("result overwrote an untaken result");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Bitmap first-fit page allocator testbench
// Drives space checks, first-fit searches, reserves and releases over a
// range of active page counts. Results are checked field by field against a
// local copy of the occupancy map. Both stream sides idle at random. The
// receiver holds off once for a long time so that the block backs up.
// ----------------------------------------------------------------------------
module tb_top import bffpa_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAP_PAGES       = 512;
	localparam int LIMIT_CYCLES    = 1_000_000;
	localparam int ITEMS_PER_PHASE = 79;
	localparam int HOLDOFF_AT      = 150;
	localparam int HOLDOFF_CYCLES  = 400;
	localparam int TAIL_CYCLES     = 100;

	typedef struct packed {
		logic       found;
		logic [8:0] first_page;
		logic [9:0] free_pages;
	} alloc_result_t;

	// Mirror of the occupancy map plus the queue of results still owed.
	class alloc_book;
		logic [MAP_PAGES-1:0] taken;
		logic [9:0]           active;
		alloc_result_t        owed[$];
		int                   errors;
		int                   results_seen;

		function new();
			taken = '0;
			active = ACTIVE_RESET;
			errors = 0;
			results_seen = 0;
		endfunction

		function void set_active(logic [9:0] value);
			active = value;
		endfunction

		function int span();
			return (active > MAP_PAGES) ? MAP_PAGES : int'(active);
		endfunction

		function void note_request(op_t op, logic [9:0] count, logic [8:0] start);
			alloc_result_t r;
			int lim;
			int run;
			r = '0;
			lim = span();
			case (op)
			OP_CHECK: begin
				for (int i = 0; i < lim; i++)
					if (!taken[9'(i)]) r.free_pages = r.free_pages + 10'd1;
				r.found = (r.free_pages >= count);
			end
			OP_SEARCH: begin
				run = 0;
				for (int i = 0; i < lim; i++) begin
					if (taken[9'(i)]) begin
						run = 0;
					end else begin
						run++;
						// a zero-length search stops at the first free page
						if (run >= count) begin
							r.found = 1'b1;
							r.first_page = 9'(i + 1 - run);
							break;
						end
					end
				end
			end
			default: begin
				// pages at or past the active count are left alone
				for (int i = 0; i < count; i++)
					if (start + i < lim) taken[9'(start + i)] = (op == OP_RESERVE);
				r.found = 1'b1;
			end
			endcase
			owed.push_back(r);
		endfunction

		function void check_result(logic [23:0] word);
			alloc_result_t want;
			results_seen++;
			if (owed.size() == 0) begin
				$error("result %h with no request outstanding", word);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (word[0] !== want.found) begin
				$error("found: expected %0d, actual %0d", want.found, word[0]);
				errors++;
			end
			if (word[9:1] !== want.first_page) begin
				$error("first_page: expected %0d, actual %0d", want.first_page, word[9:1]);
				errors++;
			end
			if (word[19:10] !== want.free_pages) begin
				$error("free_pages: expected %0d, actual %0d", want.free_pages, word[19:10]);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [9:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;       // page_count[9:0], start_page[18:10], zero pad
	logic [1:0]  s_tuser = '0;       // op[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;            // found[0], first_page[9:1], free_pages[19:10], pad

	alloc_book book = new();
	bit        sender_eager = 1'b0;

	logic [9:0] phase_active [13] = '{
		10'd512, 10'd37, 10'd0, 10'd1023, 10'd1, 10'd8, 10'd9,
		10'd200, 10'd64, 10'd513, 10'd300, 10'd16, 10'd511
	};

	bitmap_first_fit_page_allocator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #5 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 90) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_request(op_t op, logic [9:0] count, logic [8:0] start);
		int gap;
		gap = sender_eager ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, start, count};
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
		book.note_request(op, count, start);
	endtask

	task automatic send_random(int lim);
		int   roll;
		int   count;
		int   start;
		op_t  op;
		roll = $urandom_range(0, 99);
		if (roll < 2) begin
			// wipe the whole map now and then so it does not silt up
			op = OP_RELEASE;
			count = 1023;
			start = 0;
		end else begin
			if (roll < 32) op = OP_RESERVE;
			else if (roll < 52) op = OP_RELEASE;
			else if (roll < 80) op = OP_SEARCH;
			else op = OP_CHECK;
			if ($urandom_range(0, 99) < 85) begin
				case (op)
				OP_CHECK:  count = $urandom_range(0, lim + 2);
				OP_SEARCH: count = $urandom_range(0, lim / 2 + 2);
				default:   count = $urandom_range(0, lim / 4 + 2);
				endcase
			end else begin
				count = $urandom_range(0, 1023);
			end
			if ($urandom_range(0, 99) < 85) start = $urandom_range(0, (lim > 0) ? lim - 1 : 0);
			else start = $urandom_range(0, 511);
		end
		send_request(op, 10'(count), 9'(start));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (book.owed.size() != 0) @(posedge clk);
	endtask

	task automatic write_active(logic [9:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		book.set_active(value);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// empty map, all 512 pages active
		send_request(OP_CHECK, 10'd0, 9'd0);
		send_request(OP_CHECK, 10'd512, 9'd0);
		send_request(OP_CHECK, 10'd1023, 9'd511);
		send_request(OP_SEARCH, 10'd0, 9'd0);
		send_request(OP_SEARCH, 10'd512, 9'd0);
		send_request(OP_SEARCH, 10'd513, 9'd0);
		send_request(OP_RESERVE, 10'd10, 9'd0);
		send_request(OP_SEARCH, 10'd1, 9'd0);
		send_request(OP_SEARCH, 10'd0, 9'd0);
		// range runs off the end of the map
		send_request(OP_RESERVE, 10'd100, 9'd500);
		send_request(OP_CHECK, 10'd0, 9'd0);
		send_request(OP_RELEASE, 10'd2, 9'd3);
		send_request(OP_SEARCH, 10'd2, 9'd0);
		send_request(OP_SEARCH, 10'd3, 9'd0);
		send_request(OP_SEARCH, 10'd490, 9'd0);
		send_request(OP_SEARCH, 10'd491, 9'd0);
		send_request(OP_RESERVE, 10'd1023, 9'd511);
		send_request(OP_RELEASE, 10'd1023, 9'd0);
		send_request(OP_CHECK, 10'd512, 9'd0);
		send_request(OP_RESERVE, 10'd0, 9'd0);
		send_request(OP_RESERVE, 10'd512, 9'd256);
		send_request(OP_SEARCH, 10'd256, 9'd0);
		send_request(OP_SEARCH, 10'd257, 9'd0);
		send_request(OP_RELEASE, 10'd256, 9'd256);
		drain();

		foreach (phase_active[p]) begin
			write_active(phase_active[p]);
			sender_eager = (p % 4 == 1);
			repeat (ITEMS_PER_PHASE) send_random(book.span());
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (book.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin : result_sink
		int stall;
		bit steady;
		stall = 0;
		steady = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				book.check_result(m_tdata);
				if (book.results_seen % 64 == 0) steady = ($urandom_range(0, 2) == 0);
				// one long hold-off so the core and input side back up
				if (book.results_seen == HOLDOFF_AT) stall = HOLDOFF_CYCLES;
				else stall = steady ? 0 : pick_gap();
			end else if (stall > 0) begin
				stall--;
			end
			m_tready <= (stall == 0);
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
